FILE: design/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg
// shared types and constants of the generational slot table
// ----------------------------------------------------------------------------
package gst_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int SLOT_W    = 10;
    localparam int TAG_W     = 32;
    localparam int LIMIT_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int KIND_W    = 2;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_REISSUE = 2'd2,
        KIND_VERIFY  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_NO_FREE   = 3'd1,
        STATUS_RANGE     = 3'd2,
        STATUS_STALE     = 3'd3,
        STATUS_NOT_IN_USE = 3'd4
    } status_t;

    // one slot as stored in the slot memory
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [LIMIT_W-1:0] next_free;
        logic               in_use;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

FILE: design/generational_slot_table.sv
// ----------------------------------------------------------------------------
// generational_slot_table
// slot table with a linked free list and a sequence tag per slot
// ----------------------------------------------------------------------------
// A request is accepted in one cycle, which also issues the read of the
// addressed slot (or of the free-list head for an allocate) from the
// single slot memory, and the next cycle modifies the entry, writes it
// back and loads the result register; the read data of that memory is
// registered. The next request is taken in the cycle after the write, so
// no two accesses to an entry overlap. A result waits in the output
// register while the next request is accepted; the request then holds in
// its execute cycle until the output register is free.
// After reset and after every slot_limit write the block runs a clearing
// pass over all MAX_SLOTS (1024) entries that zeroes every tag, clears every
// in-use bit and links every slot to the next; no request is accepted during
// it, while slot_limit writes are taken at any time and restart the pass.
// ----------------------------------------------------------------------------
module generational_slot_table (
    input  logic                           clk,
    input  logic                           rst_n,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gst_pkg::IN_DATA_W-1:0]  s_tdata,   // slot[9:0], tag[41:10], zero pad
    input  logic [gst_pkg::KIND_W-1:0]     s_tuser,   // kind[1:0]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gst_pkg::OUT_DATA_W-1:0] m_tdata,   // status[2:0], out_slot[12:3],
                                                      // out_tag[44:13], used_count[55:45]
    // slot_limit register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gst_pkg::LIMIT_W-1:0]    cfg_data
);

    import gst_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_idx_reg, clr_idx_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [LIMIT_W-1:0]  free_head_reg, free_head_next;
    logic [LIMIT_W-1:0]  used_reg, used_next;
    kind_t               kind_reg, kind_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // memory port signals
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    slot_entry_t         ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    slot_entry_t         ram_rdata;
    logic [ENTRY_W-1:0]  ram_rdata_bits;

    // request fields
    kind_t               in_kind;
    logic [SLOT_W-1:0]   in_slot;
    logic [TAG_W-1:0]    in_tag;
    logic                req_accept;

    // result fields built in the execute cycle
    status_t             res_status;
    logic [SLOT_W-1:0]   res_slot;
    logic [TAG_W-1:0]    res_tag;
    logic                out_free;
    logic                head_empty;
    logic                slot_out_of_range;
    logic [TAG_W-1:0]    tag_bumped;
    logic [LIMIT_W-1:0]  cfg_limit;

    assign in_kind    = kind_t'(s_tuser);
    assign in_slot    = s_tdata[SLOT_W-1:0];
    assign in_tag     = s_tdata[SLOT_W +: TAG_W];

    assign s_tready   = (state_reg == ST_IDLE);
    assign req_accept = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    // output register can take a new result this cycle
    assign out_free   = !m_valid_reg || m_tready;

    assign ram_rdata  = slot_entry_t'(ram_rdata_bits);
    assign tag_bumped = ram_rdata.tag + TAG_W'(1);

    // end mark: any head or link value at or beyond the limit
    assign head_empty        = (free_head_reg >= limit_reg);
    assign slot_out_of_range = ({1'b0, slot_reg} >= limit_reg);

    // clamp the written limit into 1..MAX_SLOTS
    always_comb
    begin
        cfg_limit = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_limit = LIMIT_W'(1);
        end
        else if (cfg_data > LIMIT_W'(MAX_SLOTS))
        begin
            cfg_limit = LIMIT_W'(MAX_SLOTS);
        end
    end

    // read issued in the accept cycle: the head for allocate, else the slot
    assign ram_re    = req_accept;
    assign ram_raddr = (in_kind == KIND_ALLOC) ? free_head_reg[IDX_W-1:0]
                                               : IDX_W'(in_slot);

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        limit_next     = limit_reg;
        free_head_next = free_head_reg;
        used_next      = used_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        tag_next       = tag_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        ram_we     = 1'b0;
        ram_waddr  = clr_idx_reg;
        ram_wdata  = '0;

        res_status = STATUS_OK;
        res_slot   = slot_reg;
        res_tag    = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // rebuild one entry a cycle
                ram_we              = 1'b1;
                ram_waddr           = clr_idx_reg;
                ram_wdata.tag       = '0;
                ram_wdata.next_free = {1'b0, clr_idx_reg} + LIMIT_W'(1);
                ram_wdata.in_use    = 1'b0;
                clr_idx_next        = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_accept)
                begin
                    kind_next  = in_kind;
                    slot_next  = in_slot;
                    tag_next   = in_tag;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    ram_waddr = free_head_reg[IDX_W-1:0];
                    if (head_empty)
                    begin
                        res_status = STATUS_NO_FREE;
                        res_slot   = '0;
                        res_tag    = '0;
                    end
                    else
                    begin
                        res_slot            = free_head_reg[SLOT_W-1:0];
                        res_tag             = tag_bumped;
                        ram_we              = out_free;
                        ram_wdata.tag       = tag_bumped;
                        ram_wdata.next_free = ram_rdata.next_free;
                        ram_wdata.in_use    = 1'b1;
                        if (out_free)
                        begin
                            free_head_next = ram_rdata.next_free;
                            used_next      = used_reg + LIMIT_W'(1);
                        end
                    end
                end
                else
                begin
                    ram_waddr = IDX_W'(slot_reg);
                    if (slot_out_of_range)
                    begin
                        res_status = STATUS_RANGE;
                        res_tag    = '0;
                    end
                    else if (kind_reg == KIND_VERIFY)
                    begin
                        res_tag = ram_rdata.tag;
                        if (ram_rdata.tag != tag_reg)
                        begin
                            res_status = STATUS_STALE;
                        end
                        else if (!ram_rdata.in_use)
                        begin
                            res_status = STATUS_NOT_IN_USE;
                        end
                    end
                    else if (!ram_rdata.in_use)
                    begin
                        res_status = STATUS_NOT_IN_USE;
                        res_tag    = ram_rdata.tag;
                    end
                    else
                    begin
                        res_tag       = tag_bumped;
                        ram_we        = out_free;
                        ram_wdata.tag = tag_bumped;
                        if (kind_reg == KIND_FREE)
                        begin
                            // push onto the free list
                            ram_wdata.next_free = free_head_reg;
                            ram_wdata.in_use    = 1'b0;
                            if (out_free)
                            begin
                                free_head_next = {1'b0, slot_reg};
                                used_next      = used_reg - LIMIT_W'(1);
                            end
                        end
                        else
                        begin
                            ram_wdata.next_free = ram_rdata.next_free;
                            ram_wdata.in_use    = 1'b1;
                        end
                    end
                end

                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {used_next, res_tag, res_slot, res_status};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // a limit write rebuilds the whole table
        if (cfg_valid && cfg_ready)
        begin
            limit_next     = cfg_limit;
            free_head_next = '0;
            used_next      = '0;
            clr_idx_next   = '0;
            state_next     = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            limit_reg     <= LIMIT_W'(MAX_SLOTS);
            free_head_reg <= '0;
            used_reg      <= '0;
            kind_reg      <= KIND_ALLOC;
            slot_reg      <= '0;
            tag_reg       <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            limit_reg     <= limit_next;
            free_head_reg <= free_head_next;
            used_reg      <= used_next;
            kind_reg      <= kind_next;
            slot_reg      <= slot_next;
            tag_reg       <= tag_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
        end
    end

    gst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_bits)
    );

`ifndef SYNTHESIS
    // allocated count never exceeds the usable slots
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= limit_reg)
        else $error("used count above slot limit");

    // limit stays within its legal range
    assert property (@(posedge clk) disable iff (!rst_n)
        (limit_reg != '0) && (limit_reg <= LIMIT_W'(MAX_SLOTS)))
        else $error("slot limit out of range");

    // an accepted request moves to its execute cycle unless a rebuild starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && !cfg_valid) |=> (state_reg == ST_EXEC))
        else $error("accepted request did not reach execute");

    // a new result only comes out of an execute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result without execute cycle");

    // memory writes only during the clearing pass or execute
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_EXEC)))
        else $error("memory write outside clear or execute");
`endif

endmodule

FILE: design/gst_ram.sv
// ----------------------------------------------------------------------------
// gst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the generational slot table
// ----------------------------------------------------------------------------
// A request queue feeds a clocked driver. Each request that the block takes
// runs through a local copy of the slot table, and the handle it predicts
// joins a queue. A clocked monitor compares every result the block hands back
// against the oldest prediction, field by field. Both sides idle at random.
// A directed opener is followed by phases of random requests at different
// slot_limit settings. Free and reissue requests are mostly steered onto live
// slots, verify requests mostly onto current tags, so the table fills, drains and recycles.
// ----------------------------------------------------------------------------
module tb_top;
    import gst_pkg::*;

    localparam int QUIET_LIMIT = 20000;   // cycles with no handshake at all
    localparam int PHASE_ITEMS = 47;      // random requests per half phase

    // how a random request picks its slot once it reaches the bus
    typedef enum logic [1:0] {
        AIM_NONE,
        AIM_LIVE,
        AIM_ANY
    } aim_t;

    typedef struct {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic [TAG_W-1:0]   tag;
        aim_t               aim;
        logic [TAG_W-1:0]   skew;     // added to the current tag for verify
    } request_t;

    typedef struct {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [TAG_W-1:0]    tag;
        logic [LIMIT_W-1:0]  used;
    } handle_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LIMIT_W-1:0]     cfg_data = '0;

    // local copy of the slot table
    logic [TAG_W-1:0]   slot_tags  [MAX_SLOTS];
    logic [LIMIT_W-1:0] slot_links [MAX_SLOTS];
    bit                 slot_live  [MAX_SLOTS];
    logic [LIMIT_W-1:0] head_slot;
    logic [LIMIT_W-1:0] live_total;
    logic [LIMIT_W-1:0] table_limit;

    request_t       request_backlog [$];
    handle_result_t handle_replies  [$];
    request_t       on_bus;
    handle_result_t due;
    int             idle_pct = 36;
    int             mismatches = 0;
    int             quiet_cycles = 0;

    logic [LIMIT_W-1:0] phase_limit [0:8] = '{11'd2047, 11'd3, 11'd1, 11'd16,
                                              11'd1024, 11'd1025, 11'd0, 11'd7, 11'd2};

    generational_slot_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // a limit write clamps to 1..MAX_SLOTS and rebuilds the whole table
    function automatic void rebuild_table(input logic [LIMIT_W-1:0] lim);
        int i;
        if (lim < 1)
            lim = LIMIT_W'(1);
        if (lim > MAX_SLOTS)
            lim = LIMIT_W'(MAX_SLOTS);
        table_limit = lim;
        for (i = 0; i < MAX_SLOTS; i++)
        begin
            slot_tags[i]  = '0;
            slot_links[i] = LIMIT_W'(i + 1);
            slot_live[i]  = 1'b0;
        end
        head_slot  = '0;
        live_total = '0;
    endfunction

    // one request through the table, returns the handle the block must give
    function automatic handle_result_t apply_request(input request_t rq);
        handle_result_t r;
        logic [LIMIT_W-1:0] pick;
        r.status = STATUS_OK;
        r.slot   = rq.slot;
        r.tag    = '0;
        if (rq.kind == KIND_ALLOC)
        begin
            pick = head_slot;
            if (pick >= table_limit)
            begin
                // free list empty
                r.status = STATUS_NO_FREE;
                r.slot   = '0;
            end
            else
            begin
                head_slot       = slot_links[pick];
                slot_live[pick] = 1'b1;
                live_total      = live_total + LIMIT_W'(1);
                slot_tags[pick] = slot_tags[pick] + TAG_W'(1);
                r.slot          = pick[SLOT_W-1:0];
                r.tag           = slot_tags[pick];
            end
        end
        else if (rq.slot >= table_limit)
            r.status = STATUS_RANGE;
        else if (rq.kind == KIND_VERIFY)
        begin
            // tag compare wins over the in-use check
            r.tag = slot_tags[rq.slot];
            if (slot_tags[rq.slot] != rq.tag)
                r.status = STATUS_STALE;
            else if (!slot_live[rq.slot])
                r.status = STATUS_NOT_IN_USE;
        end
        else if (!slot_live[rq.slot])
        begin
            r.status = STATUS_NOT_IN_USE;
            r.tag    = slot_tags[rq.slot];
        end
        else
        begin
            slot_tags[rq.slot] = slot_tags[rq.slot] + TAG_W'(1);
            if (rq.kind == KIND_FREE)
            begin
                slot_links[rq.slot] = head_slot;
                head_slot           = LIMIT_W'(rq.slot);
                slot_live[rq.slot]  = 1'b0;
                live_total          = live_total - LIMIT_W'(1);
            end
            r.tag = slot_tags[rq.slot];
        end
        r.used = live_total;
        return r;
    endfunction

    // steer slot and tag from the table as it stands just before this request
    function automatic void aim_request(inout request_t rq);
        int i;
        int n;
        int k;
        n = 0;
        if (rq.aim == AIM_LIVE)
        begin
            for (i = 0; i < table_limit; i++)
                n += slot_live[i];
            if (n > 0)
            begin
                k = $urandom_range(n - 1);
                for (i = 0; i < table_limit; i++)
                begin
                    if (slot_live[i])
                    begin
                        if (k == 0)
                            rq.slot = SLOT_W'(i);
                        k--;
                    end
                end
            end
        end
        else if (rq.aim == AIM_ANY)
            rq.slot = SLOT_W'($urandom_range(table_limit - 1));
        if (rq.aim != AIM_NONE && rq.kind == KIND_VERIFY)
            rq.tag = slot_tags[rq.slot] + rq.skew;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int roll;
        int span;
        roll = $urandom_range(99);
        if (roll < 32)
            rq.kind = KIND_ALLOC;
        else if (roll < 55)
            rq.kind = KIND_FREE;
        else if (roll < 70)
            rq.kind = KIND_REISSUE;
        else
            rq.kind = KIND_VERIFY;
        // unsteered slots land up to one past the limit, sometimes anywhere
        span = (table_limit + 1 > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : table_limit + 1;
        if ($urandom_range(99) < 20)
            rq.slot = SLOT_W'($urandom_range(MAX_SLOTS - 1));
        else
            rq.slot = SLOT_W'($urandom_range(span));
        rq.tag = $urandom;
        roll = $urandom_range(99);
        if (rq.kind == KIND_VERIFY)
            rq.aim = (roll < 45) ? AIM_LIVE : (roll < 75) ? AIM_ANY : AIM_NONE;
        else
            rq.aim = (roll < 85) ? AIM_LIVE : AIM_NONE;
        roll = $urandom_range(99);
        rq.skew = (roll < 70) ? '0 : (roll < 85) ? '1 : TAG_W'(1);
        return rq;
    endfunction

    function automatic void queue_request(input kind_t k, input logic [SLOT_W-1:0] s,
                                          input logic [TAG_W-1:0] t);
        request_t rq;
        rq.kind = k;
        rq.slot = s;
        rq.tag  = t;
        rq.aim  = AIM_NONE;
        rq.skew = '0;
        request_backlog.push_back(rq);
    endfunction

    task automatic report_mismatch(input string what, input logic [TAG_W-1:0] got,
                                   input logic [TAG_W-1:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    // hold the request side back until every predicted handle has come home
    // (checked on the falling edge, once the clocked blocks have settled)
    task automatic wait_settled();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || s_tvalid || handle_replies.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        rebuild_table(v);
        cfg_valid <= 1'b0;
    endtask

    // request driver: predict on acceptance, then maybe present the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                handle_replies.push_back(apply_request(on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    on_bus = request_backlog.pop_front();
                    aim_request(on_bus);
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - SLOT_W - TAG_W){1'b0}}, on_bus.tag, on_bus.slot};
                    s_tuser  <= on_bus.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor: status[2:0], out_slot[12:3], out_tag[44:13], used_count[55:45]
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (handle_replies.size() == 0)
                    report_mismatch("result with nothing due, slot", m_tdata[12:3], '0);
                else
                begin
                    due = handle_replies.pop_front();
                    if (m_tdata[2:0] !== due.status)
                        report_mismatch("status", m_tdata[2:0], due.status);
                    if (m_tdata[12:3] !== due.slot)
                        report_mismatch("out_slot", m_tdata[12:3], due.slot);
                    if (m_tdata[44:13] !== due.tag)
                        report_mismatch("out_tag", m_tdata[44:13], due.tag);
                    if (m_tdata[55:45] !== due.used)
                        report_mismatch("used_count", m_tdata[55:45], due.used);
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on cycles in which nothing moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int p;
        int i;
        logic [LIMIT_W-1:0] lim;

        rebuild_table(11'd1024);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // full table after reset: ok, stale and not-in-use statuses, top slot index, all-ones tag
        queue_request(KIND_ALLOC,   10'd0,    32'd0);
        queue_request(KIND_VERIFY,  10'd0,    32'd1);
        queue_request(KIND_VERIFY,  10'd0,    32'd0);
        queue_request(KIND_VERIFY,  10'd1,    32'd0);
        queue_request(KIND_FREE,    10'd1,    32'd0);
        queue_request(KIND_REISSUE, 10'd1,    32'd0);
        queue_request(KIND_REISSUE, 10'd0,    32'd0);
        queue_request(KIND_VERIFY,  10'd1023, 32'hFFFF_FFFF);
        queue_request(KIND_FREE,    10'd1023, 32'd0);
        queue_request(KIND_FREE,    10'd0,    32'd0);
        queue_request(KIND_ALLOC,   10'd1023, 32'd0);
        wait_settled();

        // two slots: exhaust the list, out-of-range slots, lifo reuse
        write_limit(11'd2);
        queue_request(KIND_ALLOC,   10'd0,    32'd0);
        queue_request(KIND_ALLOC,   10'd0,    32'd0);
        queue_request(KIND_ALLOC,   10'd0,    32'd0);
        queue_request(KIND_FREE,    10'd2,    32'd0);
        queue_request(KIND_VERIFY,  10'd1023, 32'd0);
        queue_request(KIND_REISSUE, 10'd1023, 32'd0);
        queue_request(KIND_FREE,    10'd1,    32'd0);
        queue_request(KIND_ALLOC,   10'd0,    32'd0);
        queue_request(KIND_FREE,    10'd0,    32'd0);
        queue_request(KIND_FREE,    10'd1,    32'd0);
        queue_request(KIND_ALLOC,   10'd0,    32'd0);
        wait_settled();

        // a limit of zero behaves as one slot
        write_limit(11'd0);
        queue_request(KIND_ALLOC,   10'd0,    32'd0);
        queue_request(KIND_ALLOC,   10'd0,    32'd0);
        queue_request(KIND_VERIFY,  10'd1,    32'd1);
        wait_settled();

        // random phases; one runs with no idling on either side
        for (p = 0; p < 9; p++)
        begin
            idle_pct = (p == 3) ? 0 : 36;
            lim = (p == 6) ? LIMIT_W'($urandom_range(40, 4)) : phase_limit[p];
            write_limit(lim);
            for (i = 0; i < PHASE_ITEMS; i++)
                request_backlog.push_back(random_request());
            wait_settled();
            for (i = 0; i < PHASE_ITEMS; i++)
                request_backlog.push_back(random_request());
            wait_settled();
        end

        if (mismatches == 0 && handle_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: generational_slot_table.f
design/gst_pkg.sv
design/gst_ram.sv
design/generational_slot_table.sv
dv/tb_top.sv
